/* src/u6d_pkg.sv */
// Shared types and constants for the six-byte UTF-8 decoder.
// No dependencies; the lead, lane, merge and top-level files import this package.
package u6d_pkg;

	localparam int unsigned NUM_BYTES = 6;
	localparam int unsigned NUM_CONT = NUM_BYTES - 1;
	localparam int unsigned CP_W = 31;
	localparam int unsigned LEN_W = 3;

	// configuration register indexes
	localparam logic [0:0] CFG_MAX_CP = 1'd0;
	localparam logic [0:0] CFG_REJECT_SURR = 1'd1;

	localparam logic [CP_W-1:0] CP_RESET = {CP_W{1'b1}};
	localparam logic [CP_W-1:0] SURR_LO = 31'h0000_D800;
	localparam logic [CP_W-1:0] SURR_HI = 31'h0000_DFFF;

	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG = 8'h80;
	localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

	// lead byte decode: ok means a legal lead and enough bytes in the window
	typedef struct packed {
		logic ok;
		logic [LEN_W-1:0] len;
		logic [6:0] bits;
	} lead_t;

	// one continuation byte
	typedef struct packed {
		logic ok;
		logic [5:0] bits;
	} cont_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic [LEN_W-1:0] consumed;
		logic ok;
	} result_t;

endpackage

/* src/u6d_ifs.sv */
// Valid/ready channel interfaces for the decoder: byte window in, result out.
// No dependencies.
interface u6d_win_if;
	logic valid;
	logic ready;
	logic [7:0] byte_0;
	logic [7:0] byte_1;
	logic [7:0] byte_2;
	logic [7:0] byte_3;
	logic [7:0] byte_4;
	logic [7:0] byte_5;
	logic [2:0] avail_bytes;

	modport source (output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
		avail_bytes, input ready);
	modport sink (input valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
		avail_bytes, output ready);
endinterface

interface u6d_res_if;
	logic valid;
	logic ready;
	logic [30:0] code_point;
	logic [2:0] consumed;
	logic ok;

	modport source (output valid, code_point, consumed, ok, input ready);
	modport sink (input valid, code_point, consumed, ok, output ready);
endinterface

/* src/u6d_lead.sv */
// Lead byte lane: sequence length, leading payload bits, window length check.
// Depends on u6d_pkg.
module u6d_lead
	import u6d_pkg::*;
(
	input  logic [7:0]       lead,
	input  logic [2:0]       avail_bytes,
	output lead_t            info
);

	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] avail_eff;
	logic legal;

	always_comb begin
		legal = 1'b1;
		len = 3'd1;
		case (lead) inside
			8'b0???_????: len = 3'd1;
			8'b110?_????: len = 3'd2;
			8'b1110_????: len = 3'd3;
			8'b1111_0???: len = 3'd4;
			8'b1111_10??: len = 3'd5;
			8'b1111_110?: len = 3'd6;
			default: begin
				legal = 1'b0;
				len = 3'd1;
			end
		endcase
	end

	// a count of seven means a full window
	assign avail_eff = (avail_bytes == 3'd7) ? 3'd6 : avail_bytes;

	assign info.ok = legal && (avail_eff >= len);
	assign info.len = len;
	assign info.bits = lead[6:0];

endmodule

/* src/u6d_lane.sv */
// Continuation byte lane: tag check and six payload bits.
// Depends on u6d_pkg.
module u6d_lane
	import u6d_pkg::*;
(
	input  logic [7:0] data,
	output cont_t      info
);

	logic [7:0] payload;

	assign payload = data & PAYLOAD_MASK;
	assign info.ok = (data & CONT_MASK) == CONT_TAG;
	assign info.bits = payload[5:0];

endmodule

/* src/u6d_merge.sv */
// Merge stage: joins lead and continuation lanes into a code point, then
// applies the limit and surrogate tests. Depends on u6d_pkg.
module u6d_merge
	import u6d_pkg::*;
(
	input  lead_t           lead,
	input  cont_t           cont [NUM_CONT],
	input  logic [CP_W-1:0] max_cp,
	input  logic            reject_surr,
	output result_t         res
);

	logic [CP_W-1:0] cp;
	logic conts_ok;
	logic surr;
	logic good;

	always_comb begin
		conts_ok = 1'b1;
		for (int i = 0; i < NUM_CONT; i++) begin
			if ((LEN_W'(i + 1) < lead.len) && !cont[i].ok)
				conts_ok = 1'b0;
		end
	end

	always_comb begin
		case (lead.len)
			3'd1: cp = {24'd0, lead.bits};
			3'd2: cp = {20'd0, lead.bits[4:0], cont[0].bits};
			3'd3: cp = {15'd0, lead.bits[3:0], cont[0].bits, cont[1].bits};
			3'd4: cp = {10'd0, lead.bits[2:0], cont[0].bits, cont[1].bits,
				cont[2].bits};
			3'd5: cp = {5'd0, lead.bits[1:0], cont[0].bits, cont[1].bits,
				cont[2].bits, cont[3].bits};
			3'd6: cp = {lead.bits[0], cont[0].bits, cont[1].bits, cont[2].bits,
				cont[3].bits, cont[4].bits};
			default: cp = '0;
		endcase
	end

	assign surr = reject_surr && (cp >= SURR_LO) && (cp <= SURR_HI);
	assign good = lead.ok && conts_ok && (cp <= max_cp) && !surr;

	assign res.code_point = good ? cp : '0;
	assign res.consumed = good ? lead.len : '0;
	assign res.ok = good;

endmodule

/* src/utf8_six_byte_decoder.sv */
// Top level of the six-byte UTF-8 decoder: lanes, merge stage, output register.
// Depends on u6d_pkg, u6d_ifs, u6d_lead, u6d_lane and u6d_merge.
//
// Decodes one original-form UTF-8 sequence (one to six bytes, up to 31 bits)
// from the start of each six-byte window. One window is taken every clock
// unless the output holds a result nobody takes. The first register holds
// what the lead lane and the five continuation lanes found, the second is
// the output register fed by the merge stage. Overlong forms pass; a failure
// returns ok 0, consumed 0 and code point 0. The limit and surrogate registers
// must be written only while no request is in flight; the block does not check it.
module utf8_six_byte_decoder
	import u6d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	u6d_win_if.sink          win,
	u6d_res_if.source        res,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_idx,
	input  logic [CP_W-1:0]  cfg_wdata
);

	logic [CP_W-1:0] max_cp_q;
	logic            reject_q;

	logic [7:0] bytes [NUM_BYTES];
	lead_t      lead_c;
	cont_t      cont_c [NUM_CONT];

	logic       vld_s1;
	lead_t      lead_s1;
	cont_t      cont_s1 [NUM_CONT];

	result_t    merged;
	logic       vld_s2;
	result_t    res_s2;

	logic       en_s1;
	logic       en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cp_q <= CP_RESET;
			reject_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_CP: max_cp_q <= cfg_wdata;
				CFG_REJECT_SURR: reject_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign bytes[0] = win.byte_0;
	assign bytes[1] = win.byte_1;
	assign bytes[2] = win.byte_2;
	assign bytes[3] = win.byte_3;
	assign bytes[4] = win.byte_4;
	assign bytes[5] = win.byte_5;

	u6d_lead u_lead (
		.lead        (bytes[0]),
		.avail_bytes (win.avail_bytes),
		.info        (lead_c)
	);

	for (genvar g = 0; g < NUM_CONT; g++) begin : g_lane
		u6d_lane u_lane (
			.data (bytes[g+1]),
			.info (cont_c[g])
		);
	end

	// stall only when the output holds a result nobody takes
	assign en_s2 = !vld_s2 || res.ready;
	assign en_s1 = !vld_s1 || en_s2;
	assign win.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en_s1)
			vld_s1 <= win.valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && win.valid) begin
			lead_s1 <= lead_c;
			cont_s1 <= cont_c;
		end
	end

	u6d_merge u_merge (
		.lead        (lead_s1),
		.cont        (cont_s1),
		.max_cp      (max_cp_q),
		.reject_surr (reject_q),
		.res         (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en_s2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1)
			res_s2 <= merged;
	end

	assign res.valid = vld_s2;
	assign res.code_point = res_s2.code_point;
	assign res.consumed = res_s2.consumed;
	assign res.ok = res_s2.ok;

`ifndef NO_ASSERTIONS
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.ok == (res.consumed != 3'd0)))
		else $error("ok flag disagrees with consumed count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ok) |-> (res.code_point == '0))
		else $error("failed decode carries a nonzero code point");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ok) |-> (res.code_point <= max_cp_q))
		else $error("code point above configured limit");

	a_surr: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ok && reject_q) |->
		((res.code_point < SURR_LO) || (res.code_point > SURR_HI)))
		else $error("surrogate passed while rejection enabled");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(win.valid && win.ready) |=> vld_s1)
		else $error("accepted request lost before first stage");
`endif

endmodule
